// File: rtl/core/vendor_option_tlv_parser_unit_macros.svh
// Assertion macros used by the checker of the vendor option TLV parser.
`ifndef VENDOR_OPTION_TLV_PARSER_UNIT_MACROS_SVH
`define VENDOR_OPTION_TLV_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VOPT_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("vopt check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VOPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("vopt check failed");

`endif

// File: rtl/core/vopt_pkg.sv
// Shared types, codes and the tag classifier of the vendor option TLV parser.
package vopt_pkg;

  // Position counter and area size limits
  localparam int unsigned PosW            = 7;
  localparam int unsigned AreaBytesDefault = 64;

  // Configuration register map
  localparam int unsigned RegIdxW         = 1;
  localparam logic [RegIdxW-1:0] RegMagicCookie = 1'b0;
  localparam logic [31:0] MagicCookieReset = 32'h6382_5363;

  // Byte classes
  localparam logic [2:0] ClsCookie = 3'd0;
  localparam logic [2:0] ClsPad    = 3'd1;
  localparam logic [2:0] ClsEnd    = 3'd2;
  localparam logic [2:0] ClsTag    = 3'd3;
  localparam logic [2:0] ClsLen    = 3'd4;
  localparam logic [2:0] ClsData   = 3'd5;
  localparam logic [2:0] ClsBad    = 3'd6;

  // Option kinds
  localparam logic [3:0] KindNone     = 4'd0;
  localparam logic [3:0] KindNetmask  = 4'd1;
  localparam logic [3:0] KindTimeOffs = 4'd2;
  localparam logic [3:0] KindGateway  = 4'd3;
  localparam logic [3:0] KindTimeSrv  = 4'd4;
  localparam logic [3:0] KindLogSrv   = 4'd5;
  localparam logic [3:0] KindDnsSrv   = 4'd6;
  localparam logic [3:0] KindLprSrv   = 4'd7;
  localparam logic [3:0] KindHostName = 4'd8;
  localparam logic [3:0] KindDomain   = 4'd9;
  localparam logic [3:0] KindUnknown  = 4'd10;

  // Special tags
  localparam logic [7:0] TagPad = 8'd0;
  localparam logic [7:0] TagEnd = 8'd255;

  // Stream widths
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 12;

  // One result item
  typedef struct packed {
    logic        area_done;
    logic        truncated;
    logic        unknown_option;
    logic        option_done;
    logic        word_valid;
    logic [31:0] value_word;
    logic [7:0]  data_offset;
    logic [7:0]  data_byte;
    logic [3:0]  option_kind;
    logic [2:0]  byte_class;
  } vopt_result_t;

  // Map a tag to its option kind
  function automatic logic [3:0] kind_of(input logic [7:0] tag);
    logic [3:0] k;
    unique case (tag)
      8'd1:    k = KindNetmask;
      8'd2:    k = KindTimeOffs;
      8'd3:    k = KindGateway;
      8'd4:    k = KindTimeSrv;
      8'd7:    k = KindLogSrv;
      8'd6:    k = KindDnsSrv;
      8'd9:    k = KindLprSrv;
      8'd12:   k = KindHostName;
      8'd15:   k = KindDomain;
      default: k = KindUnknown;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/vopt_parse.sv
// Parser state and per-byte classification of the vendor area.
module vopt_parse #(
  parameter int unsigned VendorAreaBytes = vopt_pkg::AreaBytesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           vend_byte_i,
  input  logic                 first_i,
  input  logic [31:0]          magic_cookie_i,
  output vopt_pkg::vopt_result_t res_o
);
  import vopt_pkg::*;

  // Parse phases
  localparam logic [2:0] PhCookie = 3'd0;
  localparam logic [2:0] PhTag    = 3'd1;
  localparam logic [2:0] PhLen    = 3'd2;
  localparam logic [2:0] PhData   = 3'd3;
  localparam logic [2:0] PhDone   = 3'd4;
  localparam logic [2:0] PhBad    = 3'd5;

  localparam logic [7:0] AreaLen = 8'(VendorAreaBytes);

  logic [PosW-1:0] pos_q, pos_d;
  logic [2:0]      phase_q, phase_d;
  logic [7:0]      tag_q, tag_d;
  logic [7:0]      left_q, left_d;
  logic [7:0]      off_q, off_d;
  logic [31:0]     acc_q, acc_d;
  logic            match_q, match_d;

  logic [PosW-1:0] cur_pos;
  logic [2:0]      cur_phase;
  logic            cur_match;
  logic [7:0]      pos_next8;
  logic            last;
  logic [7:0]      remaining;
  logic [7:0]      cookie_byte;
  logic [7:0]      left_dec;
  logic [3:0]      tag_kind;
  vopt_result_t    res;

  // Restart mark overrides the control state for this byte
  assign cur_pos   = first_i ? '0 : pos_q;
  assign cur_phase = first_i ? PhCookie : phase_q;
  assign cur_match = first_i | match_q;

  assign pos_next8 = {1'b0, cur_pos} + 8'd1;
  assign last      = (pos_next8 >= AreaLen);
  assign remaining = last ? 8'd0 : (AreaLen - pos_next8);
  assign left_dec  = left_q - 8'd1;
  assign tag_kind  = kind_of(tag_q);

  // Pick the expected cookie byte, most significant first
  always_comb begin
    case (cur_pos[1:0])
      2'd0:    cookie_byte = magic_cookie_i[31:24];
      2'd1:    cookie_byte = magic_cookie_i[23:16];
      2'd2:    cookie_byte = magic_cookie_i[15:8];
      default: cookie_byte = magic_cookie_i[7:0];
    endcase
  end

  // Classify the byte and work out the next state
  always_comb begin
    res           = '0;
    res.byte_class = ClsEnd;
    res.data_byte  = vend_byte_i;
    pos_d   = cur_pos;
    phase_d = cur_phase;
    tag_d   = tag_q;
    left_d  = left_q;
    off_d   = off_q;
    acc_d   = acc_q;
    match_d = cur_match;

    unique case (cur_phase)
      PhCookie: begin
        res.byte_class = ClsCookie;
        if (cookie_byte != vend_byte_i) begin
          match_d = 1'b0;
        end
        if (cur_pos >= PosW'(3)) begin
          if (match_d) begin
            phase_d = PhTag;
          end else begin
            phase_d       = PhBad;
            res.area_done = 1'b1;
          end
        end
      end
      PhTag: begin
        if (vend_byte_i == TagPad) begin
          res.byte_class = ClsPad;
        end else if (vend_byte_i == TagEnd) begin
          res.byte_class = ClsEnd;
          res.area_done  = 1'b1;
          phase_d        = PhDone;
        end else begin
          res.byte_class     = ClsTag;
          tag_d              = vend_byte_i;
          res.option_kind    = kind_of(vend_byte_i);
          res.unknown_option = (res.option_kind == KindUnknown);
          res.truncated      = last;
          phase_d            = PhLen;
        end
      end
      PhLen: begin
        res.byte_class     = ClsLen;
        res.option_kind    = tag_kind;
        res.unknown_option = (tag_kind == KindUnknown);
        left_d             = vend_byte_i;
        off_d              = '0;
        acc_d              = '0;
        res.truncated      = (vend_byte_i > remaining);
        if (vend_byte_i == 8'd0) begin
          res.option_done = 1'b1;
          phase_d         = PhTag;
        end else begin
          phase_d = PhData;
        end
      end
      PhData: begin
        res.byte_class     = ClsData;
        res.option_kind    = tag_kind;
        res.unknown_option = (tag_kind == KindUnknown);
        res.data_offset    = off_q;
        acc_d              = {acc_q[23:0], vend_byte_i};
        res.value_word     = acc_d;
        res.word_valid     = (off_q[1:0] == 2'd3);
        off_d              = off_q + 8'd1;
        left_d             = left_dec;
        if (left_dec == 8'd0) begin
          res.option_done = 1'b1;
          phase_d         = PhTag;
        end
      end
      PhBad: begin
        res.byte_class = ClsBad;
        res.area_done  = 1'b1;
      end
      default: begin
        res.byte_class = ClsEnd;
        res.area_done  = 1'b1;
      end
    endcase

    // Advance the position, or close the area on its last byte
    if (phase_d != PhDone && phase_d != PhBad) begin
      if (last) begin
        res.area_done = 1'b1;
        phase_d       = PhDone;
      end else begin
        pos_d = pos_next8[PosW-1:0];
      end
    end
  end

  assign res_o = res;

  // Commit the state when the byte moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PhCookie;
      tag_q   <= '0;
      left_q  <= '0;
      off_q   <= '0;
      acc_q   <= '0;
      match_q <= 1'b1;
    end else if (step_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      tag_q   <= tag_d;
      left_q  <= left_d;
      off_q   <= off_d;
      acc_q   <= acc_d;
      match_q <= match_d;
    end
  end

endmodule

// File: rtl/core/vendor_option_tlv_parser_unit.sv
// A byte is taken into the input register; its result goes to the output register.
// Throughput: one byte per cycle while the result side does not stall.
// An input register and an output register part the two sides, so a byte is
// taken while a finished result still waits for its transfer.
// Reset: asynchronous, active low; clears the pipeline, restores the cookie
// register to 99.130.83.99 and puts the parser in the cookie phase.
module vendor_option_tlv_parser_unit #(
  parameter int unsigned VendorAreaBytes = vopt_pkg::AreaBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] vend_byte
  input  logic                          s_axis_tuser,  // [0] first
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] data_byte, [15:8] data_offset, [47:16] value_word
  output logic [vopt_pkg::OutDataW-1:0] m_axis_tdata,
  // [2:0] byte_class, [6:3] option_kind, [7] word_valid, [8] option_done,
  // [9] unknown_option, [10] truncated, [11] area_done
  output logic [vopt_pkg::OutUserW-1:0] m_axis_tuser,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import vopt_pkg::*;

  logic                    s1_valid_q;
  logic [7:0]              s1_byte_q;
  logic                    s1_first_q;
  logic                    out_valid_q;
  logic [OutDataW-1:0]     out_data_q, out_data_d;
  logic [OutUserW-1:0]     out_user_q, out_user_d;
  logic [31:0]             cookie_q;
  logic                    advance;
  logic                    cfg_write;
  logic [RegIdxW-1:0]      reg_idx;
  vopt_result_t            res;

  // Configuration register access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (reg_idx == RegMagicCookie) ? cookie_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cookie_q <= MagicCookieReset;
    end else if (cfg_write && reg_idx == RegMagicCookie) begin
      cookie_q <= pwdata;
    end
  end

  // Move the input register into the output register when it has room
  assign advance       = s1_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~s1_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte_q  <= s_axis_tdata;
      s1_first_q <= s_axis_tuser;
    end
  end

  vopt_parse #(
    .VendorAreaBytes(VendorAreaBytes)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .vend_byte_i   (s1_byte_q),
    .first_i       (s1_first_q),
    .magic_cookie_i(cookie_q),
    .res_o         (res)
  );

  // Pack the result fields for the output stream
  assign out_data_d = {res.value_word, res.data_offset, res.data_byte};
  assign out_user_d = {res.area_done, res.truncated, res.unknown_option,
                       res.option_done, res.word_valid, res.option_kind,
                       res.byte_class};

  // Hold the result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// File: rtl/core/vopt_checker.sv
// Port-level checks of the vendor option TLV parser, bound to the top level.
`include "vendor_option_tlv_parser_unit_macros.svh"

module vopt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [vopt_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [vopt_pkg::OutUserW-1:0] m_axis_tuser
);
  import vopt_pkg::*;

  logic [2:0] cls;
  logic [3:0] kind;
  logic       wv;
  logic       unk;

  assign cls  = m_axis_tuser[2:0];
  assign kind = m_axis_tuser[6:3];
  assign wv   = m_axis_tuser[7];
  assign unk  = m_axis_tuser[9];

  // Stalled result holds its payload
  `VOPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // Empty output side never stalls the input side
  `VOPT_ASSERT_SAME(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // Words complete only on option data bytes
  `VOPT_ASSERT_SAME(a_word_data, clk_i, rst_ni, m_axis_tvalid && wv, cls == ClsData)

  // Unknown flag agrees with the reported kind
  `VOPT_ASSERT_SAME(a_unk_kind, clk_i, rst_ni, m_axis_tvalid, unk == (kind == KindUnknown))

  // Bytes outside an option carry no kind
  `VOPT_ASSERT_SAME(a_kind_none, clk_i, rst_ni, m_axis_tvalid && (cls == ClsCookie || cls == ClsPad || cls == ClsEnd || cls == ClsBad), kind == KindNone)

endmodule

bind vendor_option_tlv_parser_unit vopt_checker u_vopt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/testbench.sv
// Self-checking stream testbench for the vendor option TLV parser unit.
module testbench;
  import vopt_pkg::*;

  localparam int unsigned AreaBytes  = AreaBytesDefault;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned MaxPrints  = 40;

  typedef enum logic [2:0] {
    PhCookie, PhTag, PhLen, PhData, PhDone, PhBad
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] vend_byte;
    logic       first;
  } area_byte_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;  // [7:0] vend_byte
  logic        s_axis_tuser  = 1'b0;  // [0] first
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] data_byte, [15:8] data_offset, [47:16] value_word
  logic [OutDataW-1:0] m_axis_tdata;
  // [2:0] byte_class, [6:3] option_kind, [7] word_valid, [8] option_done,
  // [9] unknown_option, [10] truncated, [11] area_done
  logic [OutUserW-1:0] m_axis_tuser;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  vendor_option_tlv_parser_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Parser shadow state and cookie register copy
  logic [31:0]  cookie_cfg;
  logic [6:0]   sh_pos;
  parse_phase_e sh_phase;
  logic [7:0]   sh_tag;
  logic [7:0]   sh_left;
  logic [7:0]   sh_offset;
  logic [31:0]  sh_word;
  logic         sh_match;

  area_byte_t   vend_bytes_q[$];
  vopt_result_t due_byte_results[$];
  area_byte_t   offered;

  // Control shared with the clocked processes; the stimulus changes it on falling edges only
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          send_hold     = 1'b1;
  int unsigned hold_req_cnt  = 0;
  int unsigned hold_ack_cnt  = 0;
  int unsigned rx_hold_left  = 0;

  int unsigned mismatches    = 0;
  int unsigned bytes_queued  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned areas_built   = 0;
  int unsigned cookie_writes = 0;
  int unsigned n_trunc       = 0;
  int unsigned n_bad_cookie  = 0;
  int unsigned n_words       = 0;
  int unsigned n_unknown     = 0;
  int unsigned stuck_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [3:0] tag_kind(input logic [7:0] tag);
    case (tag)
      8'd1:    return KindNetmask;
      8'd2:    return KindTimeOffs;
      8'd3:    return KindGateway;
      8'd4:    return KindTimeSrv;
      8'd7:    return KindLogSrv;
      8'd6:    return KindDnsSrv;
      8'd9:    return KindLprSrv;
      8'd12:   return KindHostName;
      8'd15:   return KindDomain;
      default: return KindUnknown;
    endcase
  endfunction

  function automatic void restart_parser();
    sh_pos    = '0;
    sh_phase  = PhCookie;
    sh_tag    = '0;
    sh_left   = '0;
    sh_offset = '0;
    sh_word   = '0;
    sh_match  = 1'b1;
  endfunction

  // Advance the shadow parser by one byte and return the result it produces
  function automatic vopt_result_t classify_byte(input logic [7:0] b, input logic first);
    vopt_result_t r;
    int unsigned  pos;
    int unsigned  room;
    bit           last;
    if (first) restart_parser();
    r = '0;
    r.byte_class = ClsEnd;
    r.data_byte  = b;
    pos  = sh_pos;
    last = (pos + 1 >= AreaBytes);
    room = last ? 0 : AreaBytes - 1 - pos;
    case (sh_phase)
      PhCookie: begin
        r.byte_class = ClsCookie;
        if (cookie_cfg[8 * (3 - (pos % 4)) +: 8] != b) sh_match = 1'b0;
        if (pos >= 3) begin
          if (sh_match) begin
            sh_phase = PhTag;
          end else begin
            sh_phase = PhBad;
            r.area_done = 1'b1;
          end
        end
      end
      PhTag: begin
        if (b == TagPad) begin
          r.byte_class = ClsPad;
        end else if (b == TagEnd) begin
          r.byte_class = ClsEnd;
          r.area_done  = 1'b1;
          sh_phase     = PhDone;
        end else begin
          r.byte_class     = ClsTag;
          sh_tag           = b;
          r.option_kind    = tag_kind(b);
          r.unknown_option = (r.option_kind == KindUnknown);
          r.truncated      = last;
          sh_phase         = PhLen;
        end
      end
      PhLen: begin
        r.byte_class     = ClsLen;
        r.option_kind    = tag_kind(sh_tag);
        r.unknown_option = (r.option_kind == KindUnknown);
        sh_left   = b;
        sh_offset = '0;
        sh_word   = '0;
        r.truncated = (b > room);
        if (b == 8'd0) begin
          r.option_done = 1'b1;
          sh_phase      = PhTag;
        end else begin
          sh_phase = PhData;
        end
      end
      PhData: begin
        r.byte_class     = ClsData;
        r.option_kind    = tag_kind(sh_tag);
        r.unknown_option = (r.option_kind == KindUnknown);
        r.data_offset    = sh_offset;
        sh_word          = {sh_word[23:0], b};
        r.value_word     = sh_word;
        r.word_valid     = (sh_offset[1:0] == 2'b11);
        sh_offset        = sh_offset + 8'd1;
        sh_left          = sh_left - 8'd1;
        if (sh_left == 8'd0) begin
          r.option_done = 1'b1;
          sh_phase      = PhTag;
        end
      end
      PhBad: begin
        r.byte_class = ClsBad;
        r.area_done  = 1'b1;
      end
      default: begin
        r.byte_class = ClsEnd;
        r.area_done  = 1'b1;
      end
    endcase
    // Close the area on its last byte, else advance the position
    if (sh_phase != PhDone && sh_phase != PhBad) begin
      if (last) begin
        r.area_done = 1'b1;
        sh_phase    = PhDone;
      end else begin
        sh_pos = 7'(pos + 1);
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short on a badly broken run
    if (mismatches <= MaxPrints) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  task automatic check_result();
    vopt_result_t want;
    if (due_byte_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata 0x%0h tuser 0x%0h",
                                m_axis_tdata, m_axis_tuser));
      return;
    end
    want = due_byte_results.pop_front();
    compare_field("data_byte",      m_axis_tdata[7:0],   want.data_byte);
    compare_field("data_offset",    m_axis_tdata[15:8],  want.data_offset);
    compare_field("value_word",     m_axis_tdata[47:16], want.value_word);
    compare_field("byte_class",     m_axis_tuser[2:0],   want.byte_class);
    compare_field("option_kind",    m_axis_tuser[6:3],   want.option_kind);
    compare_field("word_valid",     m_axis_tuser[7],     want.word_valid);
    compare_field("option_done",    m_axis_tuser[8],     want.option_done);
    compare_field("unknown_option", m_axis_tuser[9],     want.unknown_option);
    compare_field("truncated",      m_axis_tuser[10],    want.truncated);
    compare_field("area_done",      m_axis_tuser[11],    want.area_done);
    results_seen++;
    n_trunc   += want.truncated;
    n_words   += want.word_valid;
    n_unknown += want.unknown_option;
    if (want.byte_class == ClsCookie && want.area_done) n_bad_cookie++;
  endtask

  // ---------------------------------------------------------------- driver
  // Offer the next queued byte, unless held or idling at random, when the slot is free; predict on transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_byte_results.push_back(classify_byte(offered.vend_byte, offered.first));
        bytes_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (!send_hold && vend_bytes_q.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          offered = vend_bytes_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= offered.vend_byte;
          s_axis_tuser  <= offered.first;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  // Check each result transfer; stall at random or for a long requested stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        rx_hold_left = LongHold;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 stuck_cycles, due_byte_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_byte(input logic [7:0] b, input logic first);
    vend_bytes_q.push_back('{vend_byte: b, first: first});
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_known_tag();
    case ($urandom_range(8))
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'd3;
      3:       return 8'd4;
      4:       return 8'd6;
      5:       return 8'd7;
      6:       return 8'd9;
      7:       return 8'd12;
      default: return 8'd15;
    endcase
  endfunction

  // Build one vendor area: cookie, then options unless the cookie is corrupted; a full area runs to the end
  task automatic queue_area(input bit full);
    logic [31:0] ck;
    logic        mark;
    int unsigned cnt, budget, rem, len, fit, sh, sel;
    ck   = cookie_cfg;
    mark = ($urandom_range(99) >= 8);
    areas_built++;
    if ($urandom_range(99) < 12) begin
      sh = 8 * $urandom_range(3);
      ck[sh +: 8] = ck[sh +: 8] ^ 8'($urandom_range(255, 1));
    end
    for (int i = 0; i < 4; i++) push_byte(ck[8 * (3 - i) +: 8], mark && i == 0);
    if (ck != cookie_cfg) begin
      // bytes after a bad cookie are ignored
      repeat ($urandom_range(3)) push_byte(8'($urandom_range(255)), 1'b0);
      return;
    end
    cnt    = 4;
    budget = full ? AreaBytes : $urandom_range(28, 8);
    while (cnt < budget) begin
      rem = AreaBytes - cnt;
      sel = $urandom_range(99);
      if (sel < 10) begin
        push_byte(TagPad, 1'b0);
        cnt++;
        continue;
      end
      push_byte(sel < 75 ? pick_known_tag() : 8'($urandom_range(254, 1)), 1'b0);
      cnt++;
      if (cnt >= AreaBytes) break;
      if (full && rem >= 4 && rem <= 14 && $urandom_range(3) == 0)
        len = rem - 3;  // leaves the next tag on the last area byte
      else if ($urandom_range(99) < 85)
        len = $urandom_range(9);
      else
        len = $urandom_range(255, 10);
      push_byte(8'(len), 1'b0);
      cnt++;
      fit = AreaBytes - cnt;
      if (len > fit) len = fit;
      repeat (len) push_byte(8'($urandom_range(255)), 1'b0);
      cnt += len;
    end
    // Close a short area with End most of the time, else cut it off mid-stream
    if (!full && cnt < AreaBytes && $urandom_range(99) < 85) begin
      push_byte(TagEnd, 1'b0);
      repeat ($urandom_range(2)) push_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // Cookie without a restart mark, pad, known, unknown and empty options, end, data extremes, bad cookie
  task automatic queue_directed();
    push_byte(8'h63, 1'b0); push_byte(8'h82, 1'b0);
    push_byte(8'h53, 1'b0); push_byte(8'h63, 1'b0);
    push_byte(8'd1, 1'b0);  push_byte(8'd4, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(TagPad, 1'b0);
    push_byte(8'd2, 1'b0);  push_byte(8'd0, 1'b0);
    push_byte(8'd7, 1'b0);  push_byte(8'd0, 1'b0);
    push_byte(8'd15, 1'b0); push_byte(8'd0, 1'b0);
    push_byte(8'd254, 1'b0); push_byte(8'd1, 1'b0); push_byte(8'hAA, 1'b0);
    push_byte(TagEnd, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h63, 1'b1); push_byte(8'h82, 1'b0);
    push_byte(8'h53, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'd1, 1'b0);
  endtask

  // Hold the sender and wait until every predicted result has come back
  task automatic drain_block();
    while (vend_bytes_q.size() != 0) @(negedge clk_i);
    send_hold = 1'b1;
    while (s_axis_tvalid || due_byte_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic read_cookie(input logic [31:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {RegMagicCookie, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want)
      report_mismatch($sformatf("cookie read 0x%0h want 0x%0h", prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_cookie(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMagicCookie, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cookie_cfg = value;
    cookie_writes++;
    @(negedge clk_i);
    read_cookie(value);
  endtask

  initial begin
    int unsigned seg_start;
    cookie_cfg = MagicCookieReset;
    restart_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    read_cookie(MagicCookieReset);

    for (int seg = 0; seg < 5; seg++) begin
      // Walk the cookie register through its extremes, a random value and back to its reset value
      case (seg)
        1: write_cookie(32'hFFFF_FFFF);
        2: write_cookie(32'h0000_0000);
        3: write_cookie($urandom);
        4: write_cookie(MagicCookieReset);
        default: ;
      endcase
      send_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 47 : 0;
      recv_idle_pct = (seg < 2) ? 47 : (seg < 4) ? 21 : 0;
      send_hold     = 1'b0;
      if (seg == 0) queue_directed();
      seg_start = bytes_queued;
      queue_area(1'b1);
      while (bytes_queued - seg_start < 40) queue_area($urandom_range(99) < 20);
      // Stall the result side for a long stretch while bytes keep coming
      if (seg == 4) hold_req_cnt++;
      drain_block();
      send_hold = 1'b0;
      while (bytes_queued - seg_start < 70) queue_area($urandom_range(99) < 20);
      drain_block();
    end
    repeat (4) @(negedge clk_i);

    $display("Run covered %0d bytes in %0d vendor areas under %0d cookie writes; %0d results checked.",
             bytes_sent, areas_built, cookie_writes, results_seen);
    $display("It saw %0d truncation flags, %0d bad cookies, %0d full words, %0d unknown-tag bytes.",
             n_trunc, n_bad_cookie, n_words, n_unknown);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
